// File: design/usbbf_pkg.sv
// ----------------------------------------------------------------------------
// usbbf_pkg
// shared types and constants for the bulk endpoint finder
// ----------------------------------------------------------------------------
package usbbf_pkg;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_MATCH_CLASS    = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_MATCH_SUBCLASS = 1'd1;

  localparam logic [7:0] MATCH_CLASS_RST    = 8'd254;
  localparam logic [7:0] MATCH_SUBCLASS_RST = 8'd3;

  // descriptor codes
  localparam logic [7:0] TYPE_INTERFACE = 8'd4;
  localparam logic [7:0] TYPE_ENDPOINT  = 8'd5;
  localparam logic [1:0] XFER_BULK      = 2'd2;
  localparam logic [7:0] IFACE_MIN_LEN  = 8'd9;
  localparam logic [7:0] EP_MIN_LEN     = 8'd7;

  // one result beat
  typedef struct packed {
    logic        found;
    logic [7:0]  iface_number;
    logic [7:0]  in_endpoint;
    logic [15:0] in_packet_size;
    logic [7:0]  out_endpoint;
    logic [15:0] out_packet_size;
  } result_t;

endpackage

// File: design/usb_descriptor_bulk_endpoint_finder_unit.sv
// ----------------------------------------------------------------------------
// usb_descriptor_bulk_endpoint_finder_unit
// walks a configuration descriptor byte stream and reports bulk endpoints
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+----------------------------------
//  in       | in  | in_valid_i/in_ready_o  | desc_byte_i, is_last_i
//  out      | out | out_valid_o/out_ready_i| found_o, iface_number_o,
//           |     |                        | in_/out_endpoint_o, *_packet_size_o
//  cfg      | in  | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
//  one byte beat per cycle unless a held result stalls; the last byte moves
//  from the input register through the parser into the result register
//  the only stall source is a held result: a last byte waits in the input
//  register until the result register is free, and no new byte is taken
//  while it waits; bytes that are not last pass through without waiting
//  reset clears the walk state and loads the default class/subclass match
//  config writes are always taken; they must only occur while the block is idle (the block does not enforce it)
//
module usb_descriptor_bulk_endpoint_finder_unit import usbbf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // byte stream
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         desc_byte_i,
  input  logic               is_last_i,
  // result
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               found_o,
  output logic [7:0]         iface_number_o,
  output logic [7:0]         in_endpoint_o,
  output logic [15:0]        in_packet_size_o,
  output logic [7:0]         out_endpoint_o,
  output logic [15:0]        out_packet_size_o,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]         cfg_data_i
);

  // match registers
  logic [7:0] match_class_q;
  logic [7:0] match_subclass_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_class_q    <= MATCH_CLASS_RST;
      match_subclass_q <= MATCH_SUBCLASS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MATCH_CLASS:    match_class_q    <= cfg_data_i;
        CFG_MATCH_SUBCLASS: match_subclass_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       fire;
  logic       out_valid_q;
  result_t    res;
  result_t    res_q;

  // a byte proceeds unless it produces a result and the result slot is busy
  assign fire       = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= desc_byte_i;
      s1_last_q <= is_last_i;
    end
  end

  usbbf_parse u_parse (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (fire),
    .byte_i           (s1_byte_q),
    .last_i           (s1_last_q),
    .match_class_i    (match_class_q),
    .match_subclass_i (match_subclass_q),
    .result_o         (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && s1_last_q) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign found_o           = res_q.found;
  assign iface_number_o    = res_q.iface_number;
  assign in_endpoint_o     = res_q.in_endpoint;
  assign in_packet_size_o  = res_q.in_packet_size;
  assign out_endpoint_o    = res_q.out_endpoint;
  assign out_packet_size_o = res_q.out_packet_size;

`ifndef ASSERT_OFF
  // a result beat only appears after a last byte went through the parser
  a_rise_from_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire && s1_last_q))
    else $error("result beat without a last byte");

  // found flag agrees with both captured endpoints
  a_found_consistent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (found_o == ((in_endpoint_o != 8'd0) && (out_endpoint_o != 8'd0))))
    else $error("found flag inconsistent with endpoints");

  // a waiting byte is never overwritten
  a_s1_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !fire) |=> (s1_valid_q && $stable(s1_byte_q) && $stable(s1_last_q)))
    else $error("input register lost a byte");

  // a held result is not replaced before it is taken
  a_res_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(res_q)))
    else $error("held result replaced");
`endif

endmodule

// File: design/usbbf_parse.sv
// ----------------------------------------------------------------------------
// usbbf_parse
// descriptor walk state and per-byte update, result from the updated state
// ----------------------------------------------------------------------------
module usbbf_parse import usbbf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic [7:0] match_class_i,
  input  logic [7:0] match_subclass_i,
  output result_t    result_o
);

  logic [15:0] offset_q, offset_d;
  logic [15:0] total_q, total_d;
  logic [15:0] start_q, start_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  held_q [4];
  logic [7:0]  held_d [4];
  logic        match_q, match_d;
  logic        stop_q, stop_d;
  logic [7:0]  iface_q, iface_d;
  logic [7:0]  in_ep_q, in_ep_d;
  logic [15:0] in_size_q, in_size_d;
  logic [7:0]  out_ep_q, out_ep_d;
  logic [15:0] out_size_q, out_size_d;

  logic [15:0] rel;
  logic [15:0] rel_inc;
  logic        skip;
  logic [1:0]  held_idx;

  always_comb begin
    offset_d   = offset_q;
    total_d    = total_q;
    start_d    = start_q;
    len_d      = len_q;
    type_d     = type_q;
    held_d     = held_q;
    match_d    = match_q;
    stop_d     = stop_q;
    iface_d    = iface_q;
    in_ep_d    = in_ep_q;
    in_size_d  = in_size_q;
    out_ep_d   = out_ep_q;
    out_size_d = out_size_q;

    rel      = offset_q - start_q;
    rel_inc  = rel + 16'd1;
    held_idx = rel[1:0] - 2'd2;
    skip     = stop_q || ((offset_q >= 16'd4) && (offset_q >= total_q));

    // total length is captured even when the walk has stopped
    if (offset_q == 16'd2) begin
      total_d[7:0] = byte_i;
    end else if (offset_q == 16'd3) begin
      total_d[15:8] = byte_i;
    end

    if (!skip) begin
      if (rel == 16'd0) begin
        len_d  = byte_i;
        type_d = '0;
        if (byte_i == 8'd0) begin
          stop_d = 1'b1;
        end
      end else if (rel == 16'd1) begin
        type_d = byte_i;
      end else if (rel inside {[16'd2:16'd5]}) begin
        held_d[held_idx] = byte_i;
      end

      // endpoint: address, attributes, packet size low, packet size high
      if ((rel == 16'd5) && (type_q == TYPE_ENDPOINT) && (len_q >= EP_MIN_LEN) &&
          match_q && (held_q[1][1:0] == XFER_BULK)) begin
        if (held_q[0][7]) begin
          in_ep_d   = held_q[0];
          in_size_d = {byte_i, held_q[2]};
        end else begin
          out_ep_d   = held_q[0];
          out_size_d = {byte_i, held_q[2]};
        end
      end

      // interface: class in held byte 3, subclass is the current byte
      if ((rel == 16'd6) && (type_q == TYPE_INTERFACE) && (len_q >= IFACE_MIN_LEN)) begin
        if ((held_q[3] == match_class_i) && (byte_i == match_subclass_i)) begin
          match_d = 1'b1;
          iface_d = held_q[0];
        end else begin
          match_d = 1'b0;
        end
      end

      if (!stop_d && (rel_inc == {8'd0, len_d})) begin
        start_d = offset_q + 16'd1;
      end
    end

    if (offset_q != 16'hFFFF) begin
      offset_d = offset_q + 16'd1;
    end
  end

  assign result_o.found           = (in_ep_d != 8'd0) && (out_ep_d != 8'd0);
  assign result_o.iface_number    = iface_d;
  assign result_o.in_endpoint     = in_ep_d;
  assign result_o.in_packet_size  = in_size_d;
  assign result_o.out_endpoint    = out_ep_d;
  assign result_o.out_packet_size = out_size_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      total_q    <= '0;
      start_q    <= '0;
      len_q      <= '0;
      type_q     <= '0;
      held_q     <= '{default: '0};
      match_q    <= 1'b0;
      stop_q     <= 1'b0;
      iface_q    <= '0;
      in_ep_q    <= '0;
      in_size_q  <= '0;
      out_ep_q   <= '0;
      out_size_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        offset_q   <= '0;
        total_q    <= '0;
        start_q    <= '0;
        len_q      <= '0;
        type_q     <= '0;
        held_q     <= '{default: '0};
        match_q    <= 1'b0;
        stop_q     <= 1'b0;
        iface_q    <= '0;
        in_ep_q    <= '0;
        in_size_q  <= '0;
        out_ep_q   <= '0;
        out_size_q <= '0;
      end else begin
        offset_q   <= offset_d;
        total_q    <= total_d;
        start_q    <= start_d;
        len_q      <= len_d;
        type_q     <= type_d;
        held_q     <= held_d;
        match_q    <= match_d;
        stop_q     <= stop_d;
        iface_q    <= iface_d;
        in_ep_q    <= in_ep_d;
        in_size_q  <= in_size_d;
        out_ep_q   <= out_ep_d;
        out_size_q <= out_size_d;
      end
    end
  end

endmodule
